[design/chuff_pkg.sv]
`default_nettype none

package chuff_pkg;

    // Table geometry
    localparam int MAX_SYMBOLS     = 256;
    localparam int MAX_CODE_LENGTH = 16;

    // Field widths
    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int SYM_CNT_W  = 9;
    localparam int CODE_W     = 16;
    localparam int LEN_OUT_W  = 5;

    // Derived widths
    localparam int LEN_W      = $clog2(MAX_CODE_LENGTH);
    localparam int SUM_W      = $clog2(MAX_CODE_LENGTH * ((1 << BYTE_W) - 1) + 1);
    localparam int DELTA_W    = BYTE_W + 1;
    localparam int MAP_DEPTH  = 1 << BYTE_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_COUNT  = 2'd0,
        OP_LOAD_SYMBOL = 2'd1,
        OP_LOOKUP      = 2'd2
    } op_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] pos;
    } map_entry_t;

    typedef struct packed {
        logic                 hit;
        logic [LEN_OUT_W-1:0] len;
        logic [CODE_W-1:0]    code;
    } lookup_t;

endpackage

`default_nettype wire

[design/chuff_sym_map.sv]
`default_nettype none

module chuff_sym_map (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [chuff_pkg::BYTE_W-1:0]   wr_sym,
    input  wire logic [chuff_pkg::BYTE_W-1:0]   wr_pos,
    input  wire logic [chuff_pkg::BYTE_W-1:0]   rd_sym,
    output chuff_pkg::map_entry_t               rd_entry
);

    logic [chuff_pkg::MAP_DEPTH-1:0] valid_reg;
    logic [chuff_pkg::BYTE_W-1:0]    pos_mem [chuff_pkg::MAP_DEPTH];
    logic                            rd_valid_reg;
    logic [chuff_pkg::BYTE_W-1:0]    rd_pos_reg;

    // Valid bits clear at reset so unwritten symbols read as absent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_sym] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_sym];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_sym] <= wr_pos;
        end
        rd_pos_reg <= pos_mem[rd_sym];
    end

    assign rd_entry.valid = rd_valid_reg;
    assign rd_entry.pos   = rd_pos_reg;

endmodule

`default_nettype wire

[design/chuff_len_table.sv]
`default_nettype none

module chuff_len_table (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [chuff_pkg::LEN_W-1:0]    wr_idx,
    input  wire logic [chuff_pkg::BYTE_W-1:0]   wr_count,
    input  wire logic [chuff_pkg::BYTE_W-1:0]   look_pos,
    output chuff_pkg::lookup_t                  look
);

    localparam int N = chuff_pkg::MAX_CODE_LENGTH;

    // Per length: count, first position (base), one past last position (end),
    // and the first canonical code, all kept current as counts are loaded
    logic [chuff_pkg::BYTE_W-1:0] count_reg  [N];
    logic [chuff_pkg::BYTE_W-1:0] count_next [N];
    logic [chuff_pkg::SUM_W-1:0]  base_reg   [N];
    logic [chuff_pkg::SUM_W-1:0]  base_next  [N];
    logic [chuff_pkg::SUM_W-1:0]  end_reg    [N];
    logic [chuff_pkg::SUM_W-1:0]  end_next   [N];
    logic [chuff_pkg::CODE_W-1:0] first_reg  [N];
    logic [chuff_pkg::CODE_W-1:0] first_next [N];

    logic [chuff_pkg::DELTA_W-1:0] delta;
    logic [chuff_pkg::SUM_W-1:0]   delta_sum;
    logic [chuff_pkg::CODE_W-1:0]  delta_code;
    logic [N-1:0]                  hit_vec;
    logic [chuff_pkg::LEN_W-1:0]   sel;
    logic [chuff_pkg::SUM_W-1:0]   pos_ext;

    // A count change adds delta to ends from its length up and to later bases
    always_comb
    begin
        delta      = {1'b0, wr_count} - {1'b0, count_reg[wr_idx]};
        delta_sum  = {{(chuff_pkg::SUM_W - chuff_pkg::DELTA_W){delta[chuff_pkg::DELTA_W-1]}},
                      delta};
        delta_code = {{(chuff_pkg::CODE_W - chuff_pkg::DELTA_W){delta[chuff_pkg::DELTA_W-1]}},
                      delta};
        for (int l = 0; l < N; l++)
        begin
            count_next[l] = count_reg[l];
            base_next[l]  = base_reg[l];
            end_next[l]   = end_reg[l];
            first_next[l] = first_reg[l];
            if (wr_en)
            begin
                if (chuff_pkg::LEN_W'(l) == wr_idx)
                begin
                    count_next[l] = wr_count;
                end
                if (chuff_pkg::LEN_W'(l) >= wr_idx)
                begin
                    end_next[l] = end_reg[l] + delta_sum;
                end
                if (chuff_pkg::LEN_W'(l) > wr_idx)
                begin
                    base_next[l]  = base_reg[l] + delta_sum;
                    first_next[l] = first_reg[l]
                                  + (delta_code << (chuff_pkg::LEN_W'(l) - wr_idx));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < N; l++)
            begin
                count_reg[l] <= '0;
                base_reg[l]  <= '0;
                end_reg[l]   <= '0;
                first_reg[l] <= '0;
            end
        end
        else
        begin
            for (int l = 0; l < N; l++)
            begin
                count_reg[l] <= count_next[l];
                base_reg[l]  <= base_next[l];
                end_reg[l]   <= end_next[l];
                first_reg[l] <= first_next[l];
            end
        end
    end

    // Ends never decrease with length, so the lowest length whose end lies
    // past the position holds it
    always_comb
    begin
        pos_ext = chuff_pkg::SUM_W'(look_pos);
        sel     = '0;
        for (int l = 0; l < N; l++)
        begin
            hit_vec[l] = pos_ext < end_reg[l];
        end
        for (int l = N - 1; l >= 0; l--)
        begin
            if (hit_vec[l])
            begin
                sel = chuff_pkg::LEN_W'(l);
            end
        end
        look.hit  = |hit_vec;
        look.len  = chuff_pkg::LEN_OUT_W'(sel) + chuff_pkg::LEN_OUT_W'(1);
        look.code = first_reg[sel] + chuff_pkg::CODE_W'(pos_ext - base_reg[sel]);
    end

endmodule

`default_nettype wire

[design/canonical_huffman_encode_table_core.sv]
`default_nettype none

// Canonical Huffman encode table, JPEG style. Load the sixteen per-length
// counts (op 0) and the symbol positions (op 1), write symbol_count through
// cfg_we/cfg_wdata while idle, then look symbols up (op 2). busy is always
// low: one item is taken every cycle, and a lookup result appears with done
// high after its start beat, for one cycle only; the receiver cannot hold
// it off. It passes the registered read of the symbol map, then the length
// search against per-length tables that are kept up to date as each count
// is loaded, and is registered. Loads and unused op codes give no beat.
// A symbol never loaded, at a position at or beyond symbol_count, or past
// the sum of the counts returns found low with zero code and length.
module canonical_huffman_encode_table_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output wire logic                             busy,
    input  wire logic [chuff_pkg::OP_W-1:0]       op,
    input  wire logic [chuff_pkg::BYTE_W-1:0]     index,
    input  wire logic [chuff_pkg::BYTE_W-1:0]     data,
    input  wire logic                             cfg_we,
    input  wire logic [chuff_pkg::SYM_CNT_W-1:0]  cfg_wdata,
    output wire logic                             done,
    output wire logic [chuff_pkg::CODE_W-1:0]     code,
    output wire logic [chuff_pkg::LEN_OUT_W-1:0]  code_length,
    output wire logic                             found
);

    logic                              accept;
    logic                              count_wr;
    logic                              sym_wr;
    logic                              look_reg;
    logic [chuff_pkg::SYM_CNT_W-1:0]   symbol_count_reg;
    chuff_pkg::map_entry_t             map_rd;
    chuff_pkg::lookup_t                lk;
    logic                              hit;
    logic                              done_reg;
    logic [chuff_pkg::CODE_W-1:0]      code_reg;
    logic [chuff_pkg::CODE_W-1:0]      code_next;
    logic [chuff_pkg::LEN_OUT_W-1:0]   len_reg;
    logic [chuff_pkg::LEN_OUT_W-1:0]   len_next;
    logic                              found_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Drop out-of-range loads and unused op codes
    always_comb
    begin
        count_wr = 1'b0;
        sym_wr   = 1'b0;
        case (op)
            chuff_pkg::OP_LOAD_COUNT:
            begin
                count_wr = accept && ({1'b0, index}
                           < chuff_pkg::SYM_CNT_W'(chuff_pkg::MAX_CODE_LENGTH));
            end
            chuff_pkg::OP_LOAD_SYMBOL:
            begin
                sym_wr = accept && ({1'b0, index}
                         < chuff_pkg::SYM_CNT_W'(chuff_pkg::MAX_SYMBOLS));
            end
            default:
            begin
                count_wr = 1'b0;
                sym_wr   = 1'b0;
            end
        endcase
    end

    chuff_sym_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (sym_wr),
        .wr_sym   (data),
        .wr_pos   (index),
        .rd_sym   (data),
        .rd_entry (map_rd)
    );

    chuff_len_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (count_wr),
        .wr_idx   (index[chuff_pkg::LEN_W-1:0]),
        .wr_count (data),
        .look_pos (map_rd.pos),
        .look     (lk)
    );

    // Positions are below 256, so comparing against the raw count also
    // covers counts above the table size
    always_comb
    begin
        hit       = look_reg && map_rd.valid && lk.hit
                    && ({1'b0, map_rd.pos} < symbol_count_reg);
        code_next = hit ? lk.code : '0;
        len_next  = hit ? lk.len : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= '0;
            look_reg         <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                symbol_count_reg <= cfg_wdata;
            end
            look_reg <= accept && (op == chuff_pkg::OP_LOOKUP);
            done_reg <= look_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        len_reg   <= len_next;
        found_reg <= hit;
    end

    assign done        = done_reg;
    assign code        = code_reg;
    assign code_length = len_reg;
    assign found       = found_reg;

`ifndef NO_ASSERTIONS
    a_lookup_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == chuff_pkg::OP_LOOKUP) |-> ##2 done)
        else $error("lookup gave no result beat");

    a_no_spurious_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy && op == chuff_pkg::OP_LOOKUP) |-> ##2 !done)
        else $error("result beat without a lookup");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (code == '0 && code_length == '0))
        else $error("miss with non-zero code or length");

    a_hit_length: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (code_length != '0
            && code_length <= chuff_pkg::LEN_OUT_W'(chuff_pkg::MAX_CODE_LENGTH)))
        else $error("hit with code length out of range");
`endif

endmodule

`default_nettype wire

[tb/canonical_huffman_encode_table_core_tb.sv]
`timescale 1ns / 1ps

module canonical_huffman_encode_table_core_tb;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 10;
    localparam int SETTLE      = 4;
    localparam int GAP_MAX     = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int LOOKUPS     = 155;

    localparam logic [chuff_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        logic [chuff_pkg::OP_W-1:0]       op;
        logic [chuff_pkg::BYTE_W-1:0]     idx;
        logic [chuff_pkg::SYM_CNT_W-1:0]  val;
        logic                             given;
        chuff_pkg::lookup_t               want;
    } stim_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic [chuff_pkg::OP_W-1:0]       op = '0;
    logic [chuff_pkg::BYTE_W-1:0]     index = '0;
    logic [chuff_pkg::BYTE_W-1:0]     data = '0;
    logic                             cfg_we = 1'b0;
    logic [chuff_pkg::SYM_CNT_W-1:0]  cfg_wdata = '0;
    wire                              busy;
    wire                              done;
    wire [chuff_pkg::CODE_W-1:0]      code;
    wire [chuff_pkg::LEN_OUT_W-1:0]   code_length;
    wire                              found;

    // expectation travelling alongside a beat whose result is typed in
    logic                             exp_given = 1'b0;
    chuff_pkg::lookup_t               exp_fixed = '0;

    // shadow copy of the table
    logic [chuff_pkg::BYTE_W-1:0]     len_count [chuff_pkg::MAX_CODE_LENGTH];
    logic                             map_valid [chuff_pkg::MAP_DEPTH];
    logic [chuff_pkg::BYTE_W-1:0]     map_pos [chuff_pkg::MAP_DEPTH];
    logic [chuff_pkg::SYM_CNT_W-1:0]  sym_count;

    chuff_pkg::lookup_t               pending_codes [$];
    stim_row_t                        directed_rows [$];
    logic [chuff_pkg::BYTE_W-1:0]     perm [chuff_pkg::MAP_DEPTH];

    int errors = 0;
    int cycles = 0;
    int beats = 0;
    int lookups_seen = 0;
    int hits_seen = 0;
    int writes = 0;
    int idle_pct = 0;

    canonical_huffman_encode_table_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .index       (index),
        .data        (data),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .code        (code),
        .code_length (code_length),
        .found       (found)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, pending_codes.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic chuff_pkg::lookup_t encode_symbol(
        input logic [chuff_pkg::BYTE_W-1:0] sym);
        chuff_pkg::lookup_t res;
        logic [31:0]        first;
        logic [31:0]        base;
        logic [31:0]        limit;
        int                 l;
        res = '0;
        limit = (sym_count > chuff_pkg::MAX_SYMBOLS) ? chuff_pkg::MAX_SYMBOLS : sym_count;
        if (map_valid[sym] && map_pos[sym] < limit)
        begin
            first = 0;
            base = 0;
            l = 0;
            while (l < chuff_pkg::MAX_CODE_LENGTH && !res.hit)
            begin
                if (map_pos[sym] < base + len_count[l])
                begin
                    res.code = chuff_pkg::CODE_W'(first + (map_pos[sym] - base));
                    res.len = chuff_pkg::LEN_OUT_W'(l + 1);
                    res.hit = 1'b1;
                end
                else
                begin
                    base = base + len_count[l];
                    first = (first + len_count[l]) << 1;
                end
                l++;
            end
        end
        return res;
    endfunction

    // Check results and track accepted beats, all on sampled values
    always @(posedge clk)
    begin : monitor
        chuff_pkg::lookup_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < chuff_pkg::MAX_CODE_LENGTH; i++)
                len_count[i] = '0;
            for (int i = 0; i < chuff_pkg::MAP_DEPTH; i++)
            begin
                map_valid[i] = 1'b0;
                map_pos[i] = '0;
            end
            sym_count = '0;
        end
        else
        begin
            if (done)
            begin
                if (pending_codes.size() == 0)
                begin
                    $display("%0t: unexpected result: code %h length %0d found %0d",
                             $time, code, code_length, found);
                    errors++;
                end
                else
                begin
                    want = pending_codes.pop_front();
                    lookups_seen++;
                    if (found)
                        hits_seen++;
                    if (code !== want.code)
                    begin
                        $display("%0t: code mismatch: expected %h, got %h",
                                 $time, want.code, code);
                        errors++;
                    end
                    if (code_length !== want.len)
                    begin
                        $display("%0t: code_length mismatch: expected %0d, got %0d",
                                 $time, want.len, code_length);
                        errors++;
                    end
                    if (found !== want.hit)
                    begin
                        $display("%0t: found mismatch: expected %0d, got %0d",
                                 $time, want.hit, found);
                        errors++;
                    end
                end
            end
            if (cfg_we)
                sym_count = cfg_wdata;
            if (start && !busy)
            begin
                beats++;
                case (op)
                    chuff_pkg::OP_LOAD_COUNT:
                    begin
                        if (index < chuff_pkg::MAX_CODE_LENGTH)
                            len_count[index[chuff_pkg::LEN_W-1:0]] = data;
                    end
                    chuff_pkg::OP_LOAD_SYMBOL:
                    begin
                        if (index < chuff_pkg::MAX_SYMBOLS)
                        begin
                            map_valid[data] = 1'b1;
                            map_pos[data] = index;
                        end
                    end
                    chuff_pkg::OP_LOOKUP:
                    begin
                        if (exp_given)
                            pending_codes.push_back(exp_fixed);
                        else
                            pending_codes.push_back(encode_symbol(data));
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    function automatic int idle_gap();
        int g;
        g = 0;
        while (g < GAP_MAX && $urandom_range(99) < idle_pct)
            g++;
        return g;
    endfunction

    // Present one beat and hold it until accepted; returns on the accepting edge
    task automatic send_beat(input logic [chuff_pkg::OP_W-1:0] o,
                             input logic [chuff_pkg::BYTE_W-1:0] i,
                             input logic [chuff_pkg::BYTE_W-1:0] d, input logic given,
                             input chuff_pkg::lookup_t want);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= o;
        index <= i;
        data <= d;
        exp_given <= given;
        exp_fixed <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random(input logic [chuff_pkg::OP_W-1:0] o,
                               input logic [chuff_pkg::BYTE_W-1:0] i,
                               input logic [chuff_pkg::BYTE_W-1:0] d);
        send_beat(o, i, d, 1'b0, '0);
    endtask

    // Hold off until every lookup has come back, then let the pipe empty
    task automatic drain_lookups();
        start <= 1'b0;
        while (pending_codes.size() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_symbol_count(input logic [chuff_pkg::SYM_CNT_W-1:0] v);
        drain_lookups();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        writes++;
    endtask

    function automatic void add_row(input row_kind_t k, input logic [chuff_pkg::OP_W-1:0] o,
                                    input logic [chuff_pkg::BYTE_W-1:0] i,
                                    input logic [chuff_pkg::SYM_CNT_W-1:0] v,
                                    input logic g, input logic h,
                                    input logic [chuff_pkg::LEN_OUT_W-1:0] l,
                                    input logic [chuff_pkg::CODE_W-1:0] c);
        stim_row_t r;
        r.kind = k;
        r.op = o;
        r.idx = i;
        r.val = v;
        r.given = g;
        r.want.hit = h;
        r.want.len = l;
        r.want.code = c;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [chuff_pkg::BYTE_W-1:0] pick_count();
        if ($urandom_range(3) == 0)
            return chuff_pkg::BYTE_W'($urandom_range(255));
        return chuff_pkg::BYTE_W'($urandom_range(6));
    endfunction

    function automatic logic [chuff_pkg::SYM_CNT_W-1:0] phase_count(input int ph);
        case (ph)
            0: return 9'd256;
            1: return 9'd1;
            2: return 9'd511;
            4: return 9'd0;
            5: return 9'd255;
            7: return 9'd256;
            default: return chuff_pkg::SYM_CNT_W'($urandom_range(511));
        endcase
    endfunction

    initial
    begin : stimulus
        int                           n;
        int                           r;
        int                           j;
        logic [chuff_pkg::BYTE_W-1:0] tmp;
        stim_row_t                    row;

        // reset state lookups, loads with extremes, ignored beats, reused position
        add_row(ROW_BEAT, chuff_pkg::OP_LOOKUP, 8'h00, 9'h000, 1'b1, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_CFG, chuff_pkg::OP_LOOKUP, 8'h00, 9'd256, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOOKUP, 8'h00, 9'h0FF, 1'b1, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_COUNT, 8'd0, 9'd2, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_COUNT, 8'd1, 9'd1, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_COUNT, 8'd15, 9'd255, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_COUNT, 8'd16, 9'd9, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_COUNT, 8'd255, 9'd255, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_SYMBOL, 8'd0, 9'h000, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_SYMBOL, 8'd1, 9'h0FF, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_SYMBOL, 8'd2, 9'h0A5, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_SYMBOL, 8'd255, 9'h05A, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_SYMBOL, 8'd3, 9'h03C, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_SYMBOL, 8'd2, 9'h03C, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOOKUP, 8'h00, 9'h000, 1'b1, 1'b1, 5'd1, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOOKUP, 8'h00, 9'h0FF, 1'b1, 1'b1, 5'd1, 16'h0001);
        add_row(ROW_BEAT, chuff_pkg::OP_LOOKUP, 8'h00, 9'h0A5, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOOKUP, 8'h00, 9'h03C, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOOKUP, 8'h00, 9'h05A, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, OP_UNUSED, 8'd7, 9'd7, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_CFG, chuff_pkg::OP_LOOKUP, 8'h00, 9'd3, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOOKUP, 8'h00, 9'h05A, 1'b1, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOOKUP, 8'h00, 9'h0A5, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_CFG, chuff_pkg::OP_LOOKUP, 8'h00, 9'd511, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOAD_COUNT, 8'd15, 9'd0, 1'b0, 1'b0, 5'd0, 16'h0000);
        add_row(ROW_BEAT, chuff_pkg::OP_LOOKUP, 8'h00, 9'h05A, 1'b1, 1'b0, 5'd0, 16'h0000);

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                write_symbol_count(row.val);
            else
                send_beat(row.op, row.idx, row.val[chuff_pkg::BYTE_W-1:0], row.given,
                          row.want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 85;
                2: idle_pct = 0;
                default: idle_pct = 26;
            endcase
            write_symbol_count(phase_count(ph));

            for (int l = 0; l < chuff_pkg::MAX_CODE_LENGTH; l++)
                send_random(chuff_pkg::OP_LOAD_COUNT, l[chuff_pkg::BYTE_W-1:0],
                            pick_count());

            // distinct symbols in random order
            for (int i = 0; i < chuff_pkg::MAP_DEPTH; i++)
                perm[i] = i[chuff_pkg::BYTE_W-1:0];
            for (int i = chuff_pkg::MAP_DEPTH - 1; i > 0; i--)
            begin
                j = $urandom_range(i);
                tmp = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            n = (ph == 2) ? chuff_pkg::MAP_DEPTH : $urandom_range(8, 64);
            for (int p = 0; p < n; p++)
                send_random(chuff_pkg::OP_LOAD_SYMBOL, p[chuff_pkg::BYTE_W-1:0], perm[p]);

            // pause until the table is quiet before the lookup burst
            drain_lookups();

            for (int k = 0; k < LOOKUPS; k++)
            begin
                r = $urandom_range(99);
                if (r < 70)
                    send_random(chuff_pkg::OP_LOOKUP,
                                chuff_pkg::BYTE_W'($urandom_range(255)),
                                perm[$urandom_range(n - 1)]);
                else if (r < 80)
                    send_random(chuff_pkg::OP_LOOKUP,
                                chuff_pkg::BYTE_W'($urandom_range(255)),
                                chuff_pkg::BYTE_W'($urandom_range(255)));
                else
                    send_random(chuff_pkg::OP_W'($urandom_range(3)),
                                chuff_pkg::BYTE_W'($urandom_range(255)),
                                chuff_pkg::BYTE_W'($urandom_range(255)));
            end
        end

        drain_lookups();

        $display("Run covered %0d beats, %0d lookups (%0d hits), %0d symbol_count writes,",
                 beats, lookups_seen, hits_seen, writes);
        $display("over %0d phases of back-to-back, sparse and mixed issue; %0d mismatches",
                 PHASES, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
